@@ rtl/ngcr_pkg.sv @@
// ----------------------------------------------------------------------------
// ngcr_pkg: shared types and constants
// Item and result layouts, command codes, table and queue sizing, engine states.
// ----------------------------------------------------------------------------
package ngcr_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int QDEPTH      = 4;
    localparam int QPTR_W      = $clog2(QDEPTH);

    typedef enum logic {
        CMD_ENTRY = 1'b0,
        CMD_QUERY = 1'b1
    } cmd_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] gray;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } item_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] gray_distance;
        logic [6:0] distinct_count;
        logic       empty_flag;
        logic       overflow_flag;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_SCAN = 2'd1,
        ST_DONE = 2'd2
    } state_t;

endpackage

@@ rtl/ngcr_fifo.sv @@
// ----------------------------------------------------------------------------
// ngcr_fifo: item queue between front and back
// Small register queue, lets either side stall on its own.
// ----------------------------------------------------------------------------
module ngcr_fifo
    import ngcr_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  wr_valid,
    output logic  wr_ready,
    input  item_t wr_data,
    output logic  rd_valid,
    input  logic  rd_ready,
    output item_t rd_data
);
    item_t             mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wp_reg, rp_reg;
    logic [QPTR_W:0]   cnt_reg, cnt_next;
    logic              wr_en, rd_en;

    assign wr_ready = (cnt_reg != (QPTR_W+1)'(QDEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = mem_reg[rp_reg];
    assign wr_en    = wr_valid && wr_ready;
    assign rd_en    = rd_valid && rd_ready;

    always_comb begin
        cnt_next = cnt_reg;
        if (wr_en && !rd_en) cnt_next = cnt_reg + 1'b1;
        if (!wr_en && rd_en) cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (wr_en) wp_reg <= wp_reg + 1'b1;
            if (rd_en) rp_reg <= rp_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) mem_reg[wp_reg] <= wr_data;
    end
endmodule

@@ rtl/ngcr_back.sv @@
// ----------------------------------------------------------------------------
// ngcr_back: table scan engine
// Scans the stored entries one a cycle for duplicates or the nearest gray.
// ----------------------------------------------------------------------------
module ngcr_back
    import ngcr_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  item_t   in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);
    state_t           state_reg, state_next;
    item_t            cur_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] scan_reg;
    logic             dropped_reg, dropped_next;
    logic             dup_reg;
    logic [8:0]       best_reg;
    logic [23:0]      bcol_reg;
    logic [7:0]       gmem [MAX_ENTRIES];
    logic [23:0]      cmem [MAX_ENTRIES];
    logic [7:0]       rd_g_reg;
    logic [23:0]      rd_c_reg;
    logic             rd_v_reg;
    logic [7:0]       gray_diff;
    logic             scan_end, wr_en;
    result_t          res_reg;
    logic             res_v_reg;
    logic             take, load_res;

    assign take      = in_valid && in_ready;
    // last read issued and its data consumed
    assign scan_end  = (scan_reg >= count_reg) && !rd_v_reg;
    assign gray_diff = (rd_g_reg >= cur_reg.gray) ? rd_g_reg - cur_reg.gray
                                                  : cur_reg.gray - rd_g_reg;
    assign load_res  = (state_reg == ST_DONE) && (cur_reg.cmd == CMD_QUERY);
    assign wr_en     = (state_reg == ST_DONE) && (cur_reg.cmd == CMD_ENTRY) &&
                       !dup_reg && (count_reg < CNT_W'(MAX_ENTRIES));

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (take) state_next = ST_SCAN;
            ST_SCAN: if (scan_end) state_next = ST_DONE;
            ST_DONE: if (cur_reg.cmd == CMD_ENTRY || !res_v_reg || out_ready)
                         state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        in_ready = (state_reg == ST_IDLE);
    end

    always_comb begin
        count_next   = count_reg;
        dropped_next = dropped_reg;
        if (wr_en) count_next = count_reg + 1'b1;
        if ((state_reg == ST_DONE) && (cur_reg.cmd == CMD_ENTRY) && !dup_reg &&
            (count_reg >= CNT_W'(MAX_ENTRIES)))
            dropped_next = 1'b1;
        if (load_res && state_next == ST_IDLE) begin
            count_next   = '0;
            dropped_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
            res_v_reg   <= 1'b0;
            rd_v_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
            rd_v_reg    <= (state_reg == ST_SCAN) && (scan_reg < count_reg);
            if (load_res && state_next == ST_IDLE) res_v_reg <= 1'b1;
            else if (out_ready) res_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            cur_reg  <= in_data;
            scan_reg <= '0;
            dup_reg  <= 1'b0;
            best_reg <= 9'd256;
            bcol_reg <= '0;
        end
        if (state_reg == ST_SCAN && scan_reg < count_reg) begin
            rd_g_reg <= gmem[scan_reg[IDX_W-1:0]];
            rd_c_reg <= cmem[scan_reg[IDX_W-1:0]];
            scan_reg <= scan_reg + 1'b1;
        end
        if (rd_v_reg) begin
            if (rd_g_reg == cur_reg.gray) dup_reg <= 1'b1;
            if ({1'b0, gray_diff} < best_reg) begin
                best_reg <= {1'b0, gray_diff};
                bcol_reg <= rd_c_reg;
            end
        end
        if (wr_en) begin
            gmem[count_reg[IDX_W-1:0]] <= cur_reg.gray;
            cmem[count_reg[IDX_W-1:0]] <= {cur_reg.blue, cur_reg.green, cur_reg.red};
        end
        if (load_res && state_next == ST_IDLE) begin
            res_reg.red            <= bcol_reg[7:0];
            res_reg.green          <= bcol_reg[15:8];
            res_reg.blue           <= bcol_reg[23:16];
            res_reg.gray_distance  <= (count_reg == '0) ? 8'd0 : best_reg[7:0];
            res_reg.distinct_count <= 7'(count_reg);
            res_reg.empty_flag     <= (count_reg == '0);
            res_reg.overflow_flag  <= dropped_reg;
        end
    end

    assign out_valid = res_v_reg;
    assign out_data  = res_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_ENTRIES)) else $error("count overflow");
    a_query_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (load_res && state_next == ST_IDLE) |=> count_reg == '0)
        else $error("table not cleared");
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        in_ready |-> !rd_v_reg) else $error("accept during scan");
endmodule

@@ rtl/nearest_gray_color_reassign.sv @@
// ----------------------------------------------------------------------------
// nearest_gray_color_reassign: nearest gray colour lookup per pixel
// Path: a transaction is queued, then taken by the engine, which scans the
// stored entries (one table read a cycle); a query's result is registered.
// Items: the engine takes a new item only once it is done with the last one.
// Front queue of four transactions decouples input from the engine.
// Reset: aresetn synchronous, empties queue, count, overflow flag and result.
// ----------------------------------------------------------------------------
module nearest_gray_color_reassign
    import ngcr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // gray, red_in, green_in, blue_in
    input  logic        s_tuser,  // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata   // red, green, blue, gray_distance,
                                  // distinct_count, empty_flag, overflow_flag
);
    item_t   s_item, q_item;
    logic    q_valid, q_ready;
    result_t res;

    // front: classify by tuser and pack into the queue
    always_comb begin
        s_item.cmd   = cmd_t'(s_tuser);
        s_item.gray  = s_tdata[7:0];
        s_item.red   = s_tdata[15:8];
        s_item.green = s_tdata[23:16];
        s_item.blue  = s_tdata[31:24];
    end

    ngcr_fifo u_fifo (
        .aclk, .aresetn,
        .wr_valid(s_tvalid), .wr_ready(s_tready), .wr_data(s_item),
        .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_item)
    );

    ngcr_back u_back (
        .aclk, .aresetn,
        .in_valid(q_valid), .in_ready(q_ready), .in_data(q_item),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_data(res)
    );

    // pad to whole bytes above the overflow flag
    assign m_tdata = {7'b0, res.overflow_flag, res.empty_flag, res.distinct_count,
                      res.gray_distance, res.blue, res.green, res.red};
endmodule

@@ bench/nearest_gray_color_reassign_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_gray_color_reassign_test: self-checking bench for colour reassignment
// Streams entry and query transactions into the block, keeps a shadow table
// per pixel, predicts each query answer and compares it field by field.
// ----------------------------------------------------------------------------
module nearest_gray_color_reassign_test;
    import ngcr_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    // lowest field last: matches m_tdata bit order
    typedef struct packed {
        logic [6:0] pad;
        logic       ovf;
        logic       empty;
        logic [6:0] count;
        logic [7:0] distance;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } answer_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // gray, red_in, green_in, blue_in
    logic        s_tuser;   // cmd
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;   // red, green, blue, gray_distance, distinct_count,
                            // empty_flag, overflow_flag

    nearest_gray_color_reassign i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // shadow table for the current pixel
    logic [7:0]  shadow_gray [MAX_ENTRIES];
    logic [23:0] shadow_color[MAX_ENTRIES];
    int          shadow_count;
    logic        shadow_dropped;

    answer_t     pending_answers[$];
    int          errors;
    int          queries_sent;
    int          entries_sent;
    int          idle_cycles;
    bit          hold_off;

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Shadow update of one accepted transaction; queries queue an answer.
    task automatic predict_item(input cmd_t cmd, input logic [7:0] g,
                                input logic [23:0] color);
        int      best_dist;
        answer_t ans;
        int      d;
        begin
            if (cmd == CMD_ENTRY) begin
                for (int i = 0; i < shadow_count; i++)
                    if (shadow_gray[i] == g) return;
                if (shadow_count >= MAX_ENTRIES) begin
                    shadow_dropped = 1'b1;
                    return;
                end
                shadow_gray[shadow_count]  = g;
                shadow_color[shadow_count] = color;
                shadow_count++;
            end else begin
                best_dist = 256;
                ans = '0;
                for (int i = 0; i < shadow_count; i++) begin
                    d = (shadow_gray[i] >= g) ? shadow_gray[i] - g : g - shadow_gray[i];
                    // strict less-than: earliest entry keeps a tie
                    if (d < best_dist) begin
                        best_dist = d;
                        ans.red   = shadow_color[i][7:0];
                        ans.green = shadow_color[i][15:8];
                        ans.blue  = shadow_color[i][23:16];
                    end
                end
                ans.distance = (shadow_count == 0) ? 8'd0 : best_dist[7:0];
                ans.count    = shadow_count[6:0];
                ans.empty    = (shadow_count == 0);
                ans.ovf      = shadow_dropped;
                pending_answers = {pending_answers, ans};
                shadow_count   = 0;
                shadow_dropped = 1'b0;
            end
        end
    endtask

    // Offer one transaction after a random gap (none with no_gap) and wait for acceptance.
    // tvalid stays high on return; a later gap or the end drops it.
    task automatic send_item(input cmd_t cmd, input logic [7:0] g,
                             input logic [7:0] r, input logic [7:0] gr,
                             input logic [7:0] b, input bit no_gap = 0);
        int gap;
        begin
            gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19));
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tuser  <= cmd;
            s_tdata  <= {b, gr, r, g};
            @(posedge aclk);
            while (!s_tready) @(posedge aclk);
            predict_item(cmd, g, {b, gr, r});
            if (cmd == CMD_QUERY) queries_sent++;
            else entries_sent++;
        end
    endtask

    task automatic send_entry(input logic [7:0] g, input logic [23:0] c,
                              input bit no_gap = 0);
        send_item(CMD_ENTRY, g, c[7:0], c[15:8], c[23:16], no_gap);
    endtask

    task automatic send_query(input logic [7:0] g, input bit no_gap = 0);
        send_item(CMD_QUERY, g, 8'($urandom), 8'($urandom), 8'($urandom), no_gap);
    endtask

    // Result checker and receiver idling.
    initial begin
        answer_t got;
        answer_t exp;
        int      stall;
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (m_tready && m_tvalid) begin
                got = m_tdata;
                if (pending_answers.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, got);
                    errors++;
                end else begin
                    exp = pending_answers.pop_front();
                    if (got.red !== exp.red)
                        $display("%0t: red exp %h got %h", $time, exp.red, got.red);
                    if (got.green !== exp.green)
                        $display("%0t: green exp %h got %h", $time, exp.green, got.green);
                    if (got.blue !== exp.blue)
                        $display("%0t: blue exp %h got %h", $time, exp.blue, got.blue);
                    if (got.distance !== exp.distance)
                        $display("%0t: distance exp %0d got %0d", $time,
                                 exp.distance, got.distance);
                    if (got.count !== exp.count)
                        $display("%0t: count exp %0d got %0d", $time, exp.count, got.count);
                    if (got.empty !== exp.empty)
                        $display("%0t: empty exp %b got %b", $time, exp.empty, got.empty);
                    if (got.ovf !== exp.ovf)
                        $display("%0t: overflow exp %b got %b", $time, exp.ovf, got.ovf);
                    if (got !== exp) errors++;
                end
                stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
                if (stall > 0) begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
            end
            if (hold_off) m_tready <= 1'b0;
            else if (aresetn) m_tready <= 1'b1;
        end
    end

    // Watchdog: cycles with no transaction on either side.
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog expired, %0d results outstanding",
                         $time, pending_answers.size());
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    task automatic test_directed();
        begin
            send_query(8'd0);                      // empty table
            send_query(8'd255);
            send_entry(8'd0,   24'h000000);
            send_entry(8'd255, 24'hFFFFFF);
            send_query(8'd0);
            send_entry(8'd100, 24'h123456);
            send_entry(8'd100, 24'hABCDEF);        // repeated gray ignored
            send_query(8'd100);
            send_entry(8'd90,  24'h111111);        // tie: earliest wins
            send_entry(8'd110, 24'h222222);
            send_query(8'd100);
            send_entry(8'd255, 24'hA5A55A);
            send_query(8'd0);                      // max distance
            send_entry(8'd0, 24'h5A5AA5);
            send_query(8'd255);
        end
    endtask

    // Fill past capacity so entries are dropped; repeat to check the flag clears.
    task automatic test_overflow();
        begin
            for (int i = 0; i < MAX_ENTRIES + 6; i++)
                send_entry(8'(i * 3), 24'($urandom), 1);
            send_query(8'($urandom));
            for (int i = 0; i < MAX_ENTRIES; i++)
                send_entry(8'(255 - i), 24'($urandom), 1);
            send_entry(8'd255, 24'($urandom), 1);   // repeat of stored level, not a drop
            send_query(8'd128);
            send_query(8'd7);
        end
    endtask

    // Receiver holds off while the sender keeps offering.
    task automatic test_backpressure();
        begin
            hold_off = 1'b1;
            fork
                begin
                    repeat (400) @(posedge aclk);
                    hold_off = 1'b0;
                end
                for (int i = 0; i < 30; i++) begin
                    send_entry(8'($urandom), 24'($urandom), 1);
                    send_query(8'($urandom), 1);
                end
            join
        end
    endtask

    task automatic test_random();
        int n;
        int budget;
        begin
            budget = 0;
            while (budget < 900) begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, MAX_ENTRIES + 4)
                                                 : $urandom_range(0, 8);
                for (int i = 0; i < n; i++) begin
                    // narrow gray range makes repeats and ties common
                    if ($urandom_range(0, 1))
                        send_entry(8'($urandom_range(0, 15) * 16), 24'($urandom));
                    else send_entry(8'($urandom), 24'($urandom));
                end
                send_query(8'($urandom));
                budget += n + 1;
            end
        end
    endtask

    initial begin
        errors = 0;
        queries_sent = 0;
        entries_sent = 0;
        hold_off = 1'b0;
        shadow_count = 0;
        shadow_dropped = 1'b0;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = CMD_ENTRY;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_overflow();
        test_backpressure();
        test_random();
        s_tvalid <= 1'b0;

        while (pending_answers.size() != 0) @(posedge aclk);
        repeat (MAX_ENTRIES + 20) @(posedge aclk);

        $display("Covered %0d entries and %0d queries, incl. empty, tie, repeat,",
                 entries_sent, queries_sent);
        $display("full-table and long output stall cases.");
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
